// ----- src/free_list_slot_allocator_unit_macros.svh -----
// assertion macros for the slot allocator checker
`ifndef FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FLSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FLSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/flsa_pkg.sv -----
// package with types and constants of the free-list slot allocator
package flsa_pkg;

  localparam int SLOT_W         = 12;
  localparam int BUMP_W         = 13;
  localparam int CNT_W          = 17;
  localparam int MAX_MEM_DEPTH  = 4096;
  localparam int SLOT_COUNT_DEF = 4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ALLOC     = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_FREE      = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

endpackage

// ----- src/free_list_slot_allocator_unit.sv -----
// free-list slot allocator: link memory, list head, bump pointer and result register
// free, bump allocate, exhaustion: next-cycle result, one per cycle while not stalled
// allocate from the free list: the head link is read, then the pop state loads the result
// a list pop keeps the input stalled while in the pop state
// reset clears head, list flag, bump pointer, state and result valid
// link memory is left uninitialized and needs no clearing pass
module free_list_slot_allocator_unit #(
  parameter int SLOT_COUNT = flsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [flsa_pkg::SLOT_W-1:0] slot_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [flsa_pkg::SLOT_W-1:0] slot_out_o,
  output logic [1:0]                  status_o
);

  localparam int MemDepth = (SLOT_COUNT < flsa_pkg::MAX_MEM_DEPTH) ?
                            SLOT_COUNT : flsa_pkg::MAX_MEM_DEPTH;
  localparam int AddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam logic [flsa_pkg::CNT_W-1:0] SlotCountW = flsa_pkg::CNT_W'(SLOT_COUNT);
  localparam logic [flsa_pkg::CNT_W-1:0] BumpLimit  = flsa_pkg::CNT_W'(MemDepth);

  logic [flsa_pkg::SLOT_W-1:0] mem [MemDepth];
  logic [flsa_pkg::SLOT_W-1:0] rd_data_q;

  flsa_pkg::state_e            state_q, state_d;
  logic [flsa_pkg::SLOT_W-1:0] head_q, head_d;
  logic                        nonempty_q, nonempty_d;
  logic [flsa_pkg::BUMP_W-1:0] bump_q, bump_d;
  logic                        out_valid_q, out_valid_d;
  logic [flsa_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  flsa_pkg::status_e           out_status_q, out_status_d;

  logic                        out_free;
  logic                        accept;
  logic                        is_free;
  logic                        slot_in_range;
  logic                        head_in_range;
  logic                        bump_in_range;
  logic                        pop_ok;
  logic                        load;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [flsa_pkg::SLOT_W-1:0] mem_wdata;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != flsa_pkg::ST_IDLE) || !out_free;
  assign accept        = in_valid_i && !in_stall_o;
  assign is_free       = (flsa_pkg::cmd_e'(command_i) == flsa_pkg::CMD_FREE);
  assign slot_in_range = ({(flsa_pkg::CNT_W - flsa_pkg::SLOT_W)'(0), slot_in_i} < SlotCountW);
  assign head_in_range = ({(flsa_pkg::CNT_W - flsa_pkg::SLOT_W)'(0), head_q} < SlotCountW);
  assign bump_in_range = ({(flsa_pkg::CNT_W - flsa_pkg::BUMP_W)'(0), bump_q} < BumpLimit);
  assign pop_ok        = nonempty_q && head_in_range;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      flsa_pkg::ST_IDLE: begin
        if (accept && !is_free && pop_ok) begin
          state_d = flsa_pkg::ST_POP;
        end
      end
      flsa_pkg::ST_POP: begin
        if (out_free) begin
          state_d = flsa_pkg::ST_IDLE;
        end
      end
      default: state_d = flsa_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    bump_d       = bump_q;
    load         = 1'b0;
    out_slot_d   = '0;
    out_status_d = flsa_pkg::STATUS_ALLOC;
    mem_we       = 1'b0;
    mem_waddr    = slot_in_i[AddrW-1:0];
    mem_wdata    = nonempty_q ? head_q : slot_in_i;
    rd_en        = 1'b0;
    rd_addr      = head_q[AddrW-1:0];
    case (state_q)
      flsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_free) begin
            load         = 1'b1;
            out_status_d = flsa_pkg::STATUS_FREE;
            if (slot_in_range) begin
              mem_we     = 1'b1;
              head_d     = slot_in_i;
              nonempty_d = 1'b1;
            end
          end else if (pop_ok) begin
            rd_en = 1'b1;
          end else if (bump_in_range) begin
            load       = 1'b1;
            out_slot_d = bump_q[flsa_pkg::SLOT_W-1:0];
            bump_d     = bump_q + flsa_pkg::BUMP_W'(1);
          end else begin
            load         = 1'b1;
            out_status_d = flsa_pkg::STATUS_EXHAUSTED;
          end
        end
      end
      flsa_pkg::ST_POP: begin
        if (out_free) begin
          load       = 1'b1;
          out_slot_d = head_q;
          if (rd_data_q == head_q) begin
            nonempty_d = 1'b0;
            head_d     = '0;
          end else begin
            head_d = rd_data_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // link memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flsa_pkg::ST_IDLE;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      bump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      bump_q      <= bump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_slot_q   <= out_slot_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_out_o  = out_slot_q;
  assign status_o    = out_status_q;

endmodule

// ----- src/flsa_checker.sv -----
// port-level checker for the slot allocator and its bind
`include "free_list_slot_allocator_unit_macros.svh"

module flsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        command_i,
  input logic [flsa_pkg::SLOT_W-1:0] slot_in_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [flsa_pkg::SLOT_W-1:0] slot_out_o,
  input logic [1:0]                  status_o
);

  logic in_acc;
  logic out_blocked;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_blocked = out_valid_o && out_stall_i;

  `FLSA_ASSERT_IMP(a_zero_slot_unless_alloc, out_valid_o && (status_o != flsa_pkg::STATUS_ALLOC), slot_out_o == '0, "slot nonzero on non-allocation result")
  `FLSA_ASSERT_NXT(a_free_answers_next, in_acc && (command_i == flsa_pkg::CMD_FREE) && !out_blocked, out_valid_o && (status_o == flsa_pkg::STATUS_FREE), "free not answered in next cycle")
  `FLSA_ASSERT_NXT(a_alloc_busy_or_done, in_acc && (command_i == flsa_pkg::CMD_ALLOC), out_valid_o || in_stall_o, "allocate neither answered nor pending")
  `FLSA_ASSERT_NXT(a_result_held, out_blocked, out_valid_o && $stable(slot_out_o) && $stable(status_o), "stalled result changed")

endmodule

bind free_list_slot_allocator_unit flsa_checker u_flsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .slot_in_i   (slot_in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .slot_out_o  (slot_out_o),
  .status_o    (status_o)
);

// ----- tb/sv/free_list_slot_allocator_unit_test.sv -----
// testbench for the free-list slot allocator: directed and random requests, self-checking
`timescale 1ns / 100ps

module free_list_slot_allocator_unit_test;

  localparam int SLOT_COUNT     = flsa_pkg::SLOT_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BLOCKS  = 14;
  localparam int BLOCK_ITEMS    = 100;

  typedef struct packed {
    logic [flsa_pkg::SLOT_W-1:0] slot;
    flsa_pkg::status_e           status;
  } alloc_result_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  flsa_pkg::cmd_e              command     = flsa_pkg::CMD_ALLOC;
  logic [flsa_pkg::SLOT_W-1:0] slot_in     = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [flsa_pkg::SLOT_W-1:0] slot_out;
  logic [1:0]                  status;

  // predicted allocator state
  logic [flsa_pkg::SLOT_W-1:0] link_mem [SLOT_COUNT];
  logic [flsa_pkg::SLOT_W-1:0] list_head     = '0;
  logic                        list_nonempty = 1'b0;
  logic [flsa_pkg::BUMP_W-1:0] bump_next     = '0;

  alloc_result_t               pending_results[$];
  logic [flsa_pkg::SLOT_W-1:0] live_slots[$];
  int unsigned                 mismatch_count = 0;
  int unsigned                 idle_cycles    = 0;
  int unsigned                 stall_left     = 0;
  bit                          traffic_quiet  = 1'b0;

  free_list_slot_allocator_unit #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .command_i  (command),
    .slot_in_i  (slot_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .slot_out_o (slot_out),
    .status_o   (status)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [flsa_pkg::SLOT_W-1:0] random_slot();
    return flsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
  endfunction

  function automatic alloc_result_t allocator_outcome(flsa_pkg::cmd_e cmd,
                                                     logic [flsa_pkg::SLOT_W-1:0] slot);
    alloc_result_t               r;
    logic [flsa_pkg::SLOT_W-1:0] nxt;
    r.slot = '0;
    if (cmd == flsa_pkg::CMD_FREE) begin
      if (int'(slot) < SLOT_COUNT) begin
        link_mem[slot] = list_nonempty ? list_head : slot;
        list_head      = slot;
        list_nonempty  = 1'b1;
      end
      r.status = flsa_pkg::STATUS_FREE;
    end else if (list_nonempty) begin
      r.slot   = list_head;
      r.status = flsa_pkg::STATUS_ALLOC;
      nxt      = link_mem[list_head];
      // a head linking to itself is the end of the list
      if (nxt == list_head) begin
        list_nonempty = 1'b0;
        list_head     = '0;
      end else begin
        list_head = nxt;
      end
    end else if (int'(bump_next) < SLOT_COUNT) begin
      r.slot    = bump_next[flsa_pkg::SLOT_W-1:0];
      r.status  = flsa_pkg::STATUS_ALLOC;
      bump_next = bump_next + flsa_pkg::BUMP_W'(1);
    end else begin
      r.status = flsa_pkg::STATUS_EXHAUSTED;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_request(input flsa_pkg::cmd_e cmd,
                              input logic [flsa_pkg::SLOT_W-1:0] slot);
    alloc_result_t r;
    int unsigned   gap;
    if (!traffic_quiet && $urandom_range(0, 2) == 0) begin
      gap = idle_length();
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    slot_in  <= slot;
    do @(posedge clk_i); while (in_stall);
    r = allocator_outcome(cmd, slot);
    pending_results.push_back(r);
    if (cmd == flsa_pkg::CMD_ALLOC && r.status == flsa_pkg::STATUS_ALLOC) begin
      live_slots.push_back(r.slot);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic free_some_slot();
    int unsigned                 idx;
    logic [flsa_pkg::SLOT_W-1:0] s;
    if (live_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, live_slots.size() - 1);
      s   = live_slots[idx];
      live_slots.delete(idx);
    end else if (list_nonempty && $urandom_range(0, 2) == 0) begin
      // double free of the head ends the list there
      s = list_head;
    end else begin
      s = random_slot();
    end
    send_request(flsa_pkg::CMD_FREE, s);
  endtask

  task automatic test_bump_allocate();
    repeat (3) send_request(flsa_pkg::CMD_ALLOC, random_slot());
  endtask

  task automatic test_free_pop_order();
    send_request(flsa_pkg::CMD_FREE, 12'd1);
    send_request(flsa_pkg::CMD_FREE, 12'd2);
    send_request(flsa_pkg::CMD_FREE, 12'd0);
    repeat (4) send_request(flsa_pkg::CMD_ALLOC, '1);
  endtask

  task automatic test_free_extremes();
    send_request(flsa_pkg::CMD_FREE, 12'd4095);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '1);
  endtask

  task automatic test_double_free();
    send_request(flsa_pkg::CMD_FREE, 12'd4);
    send_request(flsa_pkg::CMD_FREE, 12'd4);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    // double free below the head makes a looping list
    send_request(flsa_pkg::CMD_FREE, 12'd2);
    send_request(flsa_pkg::CMD_FREE, 12'd3);
    send_request(flsa_pkg::CMD_FREE, 12'd2);
    repeat (3) send_request(flsa_pkg::CMD_ALLOC, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned alloc_pct;
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      alloc_pct     = $urandom_range(20, 80);
      traffic_quiet = ($urandom_range(0, 4) == 0);
      repeat (BLOCK_ITEMS) begin
        if ($urandom_range(1, 100) <= alloc_pct) begin
          send_request(flsa_pkg::CMD_ALLOC, random_slot());
        end else begin
          free_some_slot();
        end
      end
      traffic_quiet = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        wait_results_drained();
      end
    end
  endtask

  task automatic test_exhaustion();
    if (list_nonempty) begin
      send_request(flsa_pkg::CMD_FREE, list_head);
      send_request(flsa_pkg::CMD_ALLOC, '0);
    end
    while (int'(bump_next) < SLOT_COUNT) begin
      send_request(flsa_pkg::CMD_ALLOC, random_slot());
    end
    repeat (3) send_request(flsa_pkg::CMD_ALLOC, random_slot());
    send_request(flsa_pkg::CMD_FREE, 12'd5);
    send_request(flsa_pkg::CMD_FREE, 12'd4095);
    repeat (3) send_request(flsa_pkg::CMD_ALLOC, '0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction slot %0d status %0d",
                                  slot_out, status));
      end else begin
        want = pending_results.pop_front();
        if (slot_out !== want.slot) begin
          report_mismatch($sformatf("slot_out %0d, expected %0d", slot_out, want.slot));
        end
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (!rst_ni || traffic_quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = idle_length() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_bump_allocate();
    test_free_pop_order();
    test_free_extremes();
    test_double_free();
    wait_results_drained();
    test_random_traffic();
    wait_results_drained();
    test_exhaustion();
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
